@@ sv/sfs_pkg.sv @@
`default_nettype none
package sfs_pkg;

  // Fixed field widths
  localparam int ACTION_W  = 2;
  localparam int ELAPSED_W = 16;
  localparam int DIR_W     = 4;
  localparam int INDEX_W   = 12;
  localparam int ALPHA_W   = 8;
  localparam int MODE_W    = 4;
  localparam int PERIOD_W  = 16;
  localparam int FRAMES_W  = 8;
  localparam int NDIRS_W   = 5;
  localparam int ACCUM_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Shared divider widths
  localparam int DIV_W  = 32;
  localparam int DVSR_W = 16;

  // Default parameter values
  localparam int MAX_DIRS_DEF           = 16;
  localparam int MAX_FRAMES_PER_DIR_DEF = 255;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;
  localparam logic [ACCUM_W-1:0] ACCUM_SAT  = 32'hFFFF_FFFF;

  // Command codes
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TURN    = 2'd2;

  // Play mode codes
  localparam logic [MODE_W-1:0] MODE_LOOP       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_PINGPONG   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_STOP       = 4'd2;
  localparam logic [MODE_W-1:0] MODE_STOP_DIE   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_HIDE       = 4'd4;
  localparam logic [MODE_W-1:0] MODE_FADEOUT    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_WAITLOOP   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_STOP_FIRST = 4'd7;
  localparam logic [MODE_W-1:0] MODE_HOLD       = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIRS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = 3'd5;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  // Playback state handed to the output stage
  typedef struct packed {
    logic [FRAMES_W-1:0] frame_offset;
    logic [DIR_W-1:0]    current_dir;
    logic [ALPHA_W-1:0]  alpha;
    logic                stopped;
    logic                hidden;
    logic                reverse;
  } play_state_t;

  // Frames in one run: zero counts as one, clamp to the maximum
  function automatic logic [FRAMES_W-1:0] run_len(input logic [FRAMES_W-1:0] frames,
                                                   input logic [FRAMES_W-1:0] max_frames);
    logic [FRAMES_W-1:0] f;
    f = frames;
    if (f == '0) f = FRAMES_W'(1);
    if (f > max_frames) f = max_frames;
    return f;
  endfunction

endpackage
`default_nettype wire

@@ sv/sprite_frame_sequencer.sv @@
`default_nettype none
// Sprite animation frame sequencer.
// Input words arrive on s_axis: tuser carries the command (tick, restart,
// turn), tdata the elapsed milliseconds and the target direction. Each
// accepted word gives exactly one result word on m_axis: frame index, alpha
// and the stopped, visible, reverse and last-frame flags.
// The user must write registers through cfg_we/cfg_index/cfg_data only
// while idle; the block does not enforce this. Restart, turn and ticks
// that do not reach a frame boundary go from EXEC (ticks via CHECK) to
// FINISH. A tick that crosses a boundary runs one 32-step shift-subtract
// division in DIVIDE to get the number of frame steps, then STEP; a
// fade-out step runs the same divider a second time for the alpha value.
// One word is worked at a time and s_axis_tready is high only between
// words, so the next word is taken in the cycle after the previous result
// is loaded. The result sits in an output register, so the next word is
// accepted while it waits. If the receiver stalls with a second result
// ready, the block holds that result and takes no new word until the
// register frees. Reset (rst, synchronous) restores register defaults,
// clears playback state, sets alpha to full and drops m_axis_tvalid.
module sprite_frame_sequencer #(
  parameter int MAX_DIRS           = sfs_pkg::MAX_DIRS_DEF,
  parameter int MAX_FRAMES_PER_DIR = sfs_pkg::MAX_FRAMES_PER_DIR_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // elapsed_ms[15:0], direction[19:16], zero fill [23:20]
  input  wire logic [23:0]                    s_axis_tdata,
  // action[1:0]
  input  wire logic [sfs_pkg::ACTION_W-1:0]   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // frame_index[11:0], alpha[19:12], stopped[20], visible[21],
  // playing_back[22], at_last_frame[23]
  output logic [23:0]                         m_axis_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_DIVIDE = 6'b001000,
    ST_STEP   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  // Fade wait shares the divider; tracked by a flag beside ST_DIVIDE
  state_t state;
  logic   fading;

  // Configuration
  logic [MODE_W-1:0]   play_mode;
  logic [PERIOD_W-1:0] frame_period_ms;
  logic [FRAMES_W-1:0] frames_per_dir;
  logic [NDIRS_W-1:0]  num_dirs;
  logic [PERIOD_W-1:0] fade_time_ms;
  logic                descending;

  // Playback state
  logic [FRAMES_W-1:0] frame_offset;
  logic [DIR_W-1:0]    current_dir;
  logic [ACCUM_W-1:0]  time_accum;
  logic [ACCUM_W-1:0]  over_time;
  logic                stopped;
  logic                reverse;
  logic                hidden;
  logic [ALPHA_W-1:0]  alpha;

  // Latched command
  logic [ACTION_W-1:0]  in_action;
  logic [ELAPSED_W-1:0] in_elapsed;
  logic [DIR_W-1:0]     in_dir;
  logic [DIV_W-1:0]     steps;

  // Divider link
  div_req_t          div_req;
  logic              div_busy;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [DVSR_W-1:0] div_rem;

  // Output link
  play_state_t snap;
  logic        out_free;
  logic        out_load;

  // Combinational helpers
  logic [FRAMES_W-1:0] f;
  logic [FRAMES_W-1:0] last;
  logic [ACCUM_W:0]    accum_sum;
  logic [ACCUM_W:0]    over_sum;
  logic [ACCUM_W-1:0]  accum_add;
  logic [ACCUM_W-1:0]  over_add;
  logic                rev_sub;
  logic [DIV_W+1:0]    pos;
  logic                pos_neg;
  logic                pos_past;
  logic [DIR_W-1:0]    turn_dir;
  logic [PERIOD_W-1:0] fade_left;
  logic [DIV_W-1:0]    fade_num;

  always_comb begin
    f         = run_len(frames_per_dir, FRAMES_W'(MAX_FRAMES_PER_DIR));
    last      = f - FRAMES_W'(1);
    accum_sum = {1'b0, time_accum} + (ACCUM_W+1)'(in_elapsed);
    over_sum  = {1'b0, over_time} + (ACCUM_W+1)'(in_elapsed);
    accum_add = accum_sum[ACCUM_W] ? ACCUM_SAT : accum_sum[ACCUM_W-1:0];
    over_add  = over_sum[ACCUM_W] ? ACCUM_SAT : over_sum[ACCUM_W-1:0];
    rev_sub   = (play_mode == MODE_PINGPONG) && reverse;
    if (rev_sub)
      pos = (DIV_W+2)'(frame_offset) - (DIV_W+2)'(steps);
    else
      pos = (DIV_W+2)'(frame_offset) + (DIV_W+2)'(steps);
    pos_neg  = pos[DIV_W+1];
    pos_past = ~pos_neg && (pos >= (DIV_W+2)'(f));
    if ((NDIRS_W'(in_dir) >= num_dirs) || (NDIRS_W'(in_dir) >= NDIRS_W'(MAX_DIRS)))
      turn_dir = '0;
    else
      turn_dir = in_dir;
    // remaining fade time times 255 as a shift and subtract
    fade_left = fade_time_ms - over_time[PERIOD_W-1:0];
    fade_num  = DIV_W'({fade_left, 8'd0}) - DIV_W'(fade_left);
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign out_load      = (state == ST_FINISH) && out_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode       <= MODE_LOOP;
      frame_period_ms <= PERIOD_W'(100);
      frames_per_dir  <= FRAMES_W'(1);
      num_dirs        <= NDIRS_W'(8);
      fade_time_ms    <= '0;
      descending      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLAY_MODE:  play_mode       <= cfg_data[MODE_W-1:0];
        CFG_PERIOD:     frame_period_ms <= cfg_data[PERIOD_W-1:0];
        CFG_FRAMES:     frames_per_dir  <= cfg_data[FRAMES_W-1:0];
        CFG_NUM_DIRS:   num_dirs        <= cfg_data[NDIRS_W-1:0];
        CFG_FADE_TIME:  fade_time_ms    <= cfg_data[PERIOD_W-1:0];
        CFG_DESCENDING: descending      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Latch the command word
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action  <= s_axis_tuser;
      in_elapsed <= s_axis_tdata[ELAPSED_W-1:0];
      in_dir     <= s_axis_tdata[ELAPSED_W+DIR_W-1:ELAPSED_W];
    end
  end

  // Sequence one command, using the shared divider for frame steps and fade
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fading        <= 1'b0;
      div_req.start <= 1'b0;
      frame_offset  <= '0;
      current_dir   <= '0;
      time_accum    <= '0;
      over_time     <= '0;
      stopped       <= 1'b0;
      reverse       <= 1'b0;
      hidden        <= 1'b0;
      alpha         <= ALPHA_FULL;
    end else begin
      div_req.start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_FINISH;
          case (in_action)
            ACT_TICK: begin
              if (play_mode == MODE_STOP_FIRST) begin
                stopped <= 1'b1;
              end else if (!stopped) begin
                time_accum <= accum_add;
                if (frame_offset >= last) over_time <= over_add;
                state <= ST_CHECK;
              end
            end
            ACT_RESTART: begin
              frame_offset <= '0;
              time_accum   <= '0;
              over_time    <= '0;
              stopped      <= 1'b0;
              reverse      <= 1'b0;
              hidden       <= 1'b0;
            end
            ACT_TURN: begin
              if (turn_dir != current_dir) begin
                current_dir <= turn_dir;
                time_accum  <= '0;
                over_time   <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_CHECK: begin
          if ((frame_period_ms == '0) || (time_accum <= ACCUM_W'(frame_period_ms))) begin
            state <= ST_FINISH;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= time_accum - ACCUM_W'(1);
            div_req.divisor  <= frame_period_ms;
            fading           <= 1'b0;
            state            <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            if (fading) begin
              alpha <= div_quo[ALPHA_W-1:0];
              state <= ST_FINISH;
            end else begin
              steps      <= div_quo;
              time_accum <= ACCUM_W'(div_rem) + ACCUM_W'(1);
              state      <= ST_STEP;
            end
          end
        end
        ST_STEP: begin
          state <= ST_FINISH;
          if (reverse && pos_neg) begin
            frame_offset <= (f >= FRAMES_W'(2)) ? FRAMES_W'(1) : '0;
            reverse      <= 1'b0;
          end else if (pos_past) begin
            case (play_mode) inside
              MODE_LOOP: begin
                frame_offset <= '0;
                stopped      <= 1'b0;
              end
              MODE_PINGPONG: begin
                frame_offset <= (f >= FRAMES_W'(2)) ? (f - FRAMES_W'(2)) : '0;
                reverse      <= 1'b1;
              end
              MODE_STOP, MODE_STOP_DIE: begin
                frame_offset <= last;
                stopped      <= 1'b1;
              end
              MODE_HIDE: begin
                frame_offset <= last;
                stopped      <= 1'b1;
                hidden       <= 1'b1;
              end
              MODE_FADEOUT: begin
                frame_offset <= last;
                if (over_time >= ACCUM_W'(fade_time_ms)) begin
                  stopped <= 1'b1;
                end else begin
                  div_req.start    <= 1'b1;
                  div_req.dividend <= fade_num;
                  div_req.divisor  <= fade_time_ms;
                  fading           <= 1'b1;
                  state            <= ST_DIVIDE;
                end
              end
              MODE_WAITLOOP: frame_offset <= '0;
              default: ;
            endcase
          end else begin
            frame_offset <= pos[FRAMES_W-1:0];
          end
        end
        ST_FINISH: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sfs_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign snap = '{frame_offset: frame_offset, current_dir: current_dir, alpha: alpha,
                  stopped: stopped, hidden: hidden, reverse: reverse};

  sfs_out_stage #(
    .MAX_FRAMES_PER_DIR (MAX_FRAMES_PER_DIR)
  ) u_out_stage (
    .clk            (clk),
    .rst            (rst),
    .load           (out_load),
    .snap           (snap),
    .frames_per_dir (frames_per_dir),
    .descending     (descending),
    .free           (out_free),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata)
  );

  // A result waiting on a stalled receiver keeps the sequencer parked
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && !out_free |=> (state == ST_FINISH))
    else $error("sequencer left FINISH with the output register full");

  // The divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider finished outside the divide wait");

  // A new division is never requested while one is running
  a_div_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

  // A tick in stop-first mode always ends playback
  a_stop_first: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) && (in_action == ACT_TICK) && (play_mode == MODE_STOP_FIRST)
    |=> stopped)
    else $error("stop-first tick did not stop playback");

endmodule
`default_nettype wire

@@ sv/sfs_divider.sv @@
`default_nettype none
module sfs_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sfs_pkg::div_req_t          req,
  output logic                            busy,
  output logic                            done,
  output logic [sfs_pkg::DIV_W-1:0]       quotient,
  output logic [sfs_pkg::DVSR_W-1:0]      remainder
);
  import sfs_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]  count;
  logic [DVSR_W-1:0] dvsr;
  logic [DVSR_W-1:0] rem;
  logic [DIV_W-1:0]  quo;
  logic [DVSR_W:0]   shifted;
  logic [DVSR_W:0]   diff;
  logic              fits;
  logic [DVSR_W-1:0] rem_next;

  // One restoring step: shift in the next dividend bit, try a subtract
  always_comb begin
    shifted  = {rem, quo[DIV_W-1]};
    diff     = shifted - {1'b0, dvsr};
    fits     = ~diff[DVSR_W];
    rem_next = fits ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold the partial remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

@@ sv/sfs_out_stage.sv @@
`default_nettype none
module sfs_out_stage #(
  parameter int MAX_FRAMES_PER_DIR = sfs_pkg::MAX_FRAMES_PER_DIR_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire sfs_pkg::play_state_t         snap,
  input  wire logic [sfs_pkg::FRAMES_W-1:0] frames_per_dir,
  input  wire logic                         descending,
  output logic                              free,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // frame_index[11:0], alpha[19:12], stopped[20], visible[21],
  // playing_back[22], at_last_frame[23]
  output logic [23:0]                       m_axis_tdata
);
  import sfs_pkg::*;

  logic [FRAMES_W-1:0] f;
  logic [FRAMES_W-1:0] last;
  logic [FRAMES_W-1:0] shown;
  logic [INDEX_W-1:0]  base;
  logic [INDEX_W-1:0]  frame_index;

  // Form the displayed frame from direction base and offset
  always_comb begin
    f     = run_len(frames_per_dir, FRAMES_W'(MAX_FRAMES_PER_DIR));
    last  = f - FRAMES_W'(1);
    if (descending)
      shown = (snap.frame_offset <= last) ? (last - snap.frame_offset) : '0;
    else
      shown = snap.frame_offset;
    base        = INDEX_W'(snap.current_dir) * INDEX_W'(f);
    frame_index = base + INDEX_W'(shown);
  end

  assign free = ~m_axis_tvalid | m_axis_tready;

  // Hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {(snap.frame_offset == last), snap.reverse, ~snap.hidden,
                       snap.stopped, snap.alpha, frame_index};
    end
  end

endmodule
`default_nettype wire
